// ===== sv/bfd_pkg.sv =====
// bfd_pkg: shared types and register codes for the box filter downscaler
// depends on nothing
`default_nettype none
package bfd_pkg;
	typedef enum logic [1:0] {
		REG_SRC_WIDTH  = 2'd0,
		REG_SRC_HEIGHT = 2'd1,
		REG_DST_WIDTH  = 2'd2,
		REG_CHANNELS   = 2'd3
	} reg_idx_t;

	localparam logic [12:0] RST_SRC_WIDTH  = 13'd640;
	localparam logic [12:0] RST_SRC_HEIGHT = 13'd480;
	localparam logic [12:0] RST_DST_WIDTH  = 13'd160;
	localparam logic [2:0]  RST_CHANNELS   = 3'd3;

	// control word handed from the position tracker to the accumulate stage
	typedef struct packed {
		logic in_box;
		logic clear;
		logic emit;
		logic last;
	} acc_ctl_t;
endpackage
`default_nettype wire

// ===== sv/bfd_div.sv =====
// bfd_div: restoring divider, one quotient bit per cycle
// depends on nothing
`default_nettype none
module bfd_div #(
	parameter int NW = 48,
	parameter int DW = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               busy,
	output logic [NW-1:0]      quo
);
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] rem_q;
	logic [DW:0]   acc_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic [DW+1:0] trial;
	logic [DW:0]   shifted;

	assign shifted = {acc_q[DW-1:0], rem_q[NW-1]};
	assign trial   = {1'b0, shifted} - {2'b0, den_q};

	// shift and subtract
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy  <= 1'b1;
			cnt_q <= CW'(NW);
			rem_q <= num;
			acc_q <= '0;
			den_q <= den;
		end else if (busy) begin
			rem_q <= {rem_q[NW-2:0], ~trial[DW+1]};
			acc_q <= trial[DW+1] ? shifted : trial[DW:0];
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) busy <= 1'b0;
		end
	end
	assign quo = rem_q;
endmodule
`default_nettype wire

// ===== sv/box_filter_downscale.sv =====
// box_filter_downscale: area-average thumbnail scaler with a column sum store
// depends on bfd_pkg and bfd_div
//
// Usage: source pixels enter on the pix channel (pix_valid/pix_stall) in raster
// order; thumbnail pixels leave on the avg channel (avg_valid/avg_stall), the
// bottom-right one with frame_last set. Registers are to be written over the
// APB port only while the block is idle, which the block does not enforce.
// Each pixel is read from the sum store, updated and written back. A pixel
// that completes a box then runs its channel sums through one shared serial
// divider. A pixel that ends a box row or the frame also clears the sum store,
// one entry a cycle over MAX_WIDTH entries.
// After reset and after every register write the block derives the thumbnail
// height and the step ratios (three serial divides) and then clears all
// MAX_WIDTH entries of the sum store; no pixel is taken meanwhile.
// A stalled result holds in the output register; the next pixel is still
// processed, but its result waits until the held one has been delivered.
`default_nettype none
module box_filter_downscale #(
	parameter int MAX_WIDTH    = 4096,
	parameter int MAX_HEIGHT   = 4096,
	parameter int MAX_CHANNELS = 4,
	parameter int FRAC_BITS    = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        pix_valid,
	output logic             pix_stall,
	input  wire logic [7:0]  pix_ch0,
	input  wire logic [7:0]  pix_ch1,
	input  wire logic [7:0]  pix_ch2,
	input  wire logic [7:0]  pix_ch3,
	output logic             avg_valid,
	input  wire logic        avg_stall,
	output logic [7:0]       avg_ch0,
	output logic [7:0]       avg_ch1,
	output logic [7:0]       avg_ch2,
	output logic [7:0]       avg_ch3,
	output logic             frame_last
);
	localparam int XW  = $clog2(MAX_WIDTH + 1);
	localparam int YW  = $clog2(MAX_HEIGHT + 1);
	localparam int AW  = $clog2(MAX_WIDTH);
	localparam int SW  = XW + FRAC_BITS + 1;
	localparam int NW  = 2 * XW + FRAC_BITS + 2;
	localparam int CHW = 3;
	localparam int SUMW = 32;

	typedef enum logic [3:0] {
		ST_DIV_H, ST_WAIT_H, ST_DIV_X, ST_WAIT_X, ST_DIV_Y, ST_WAIT_Y,
		ST_BND, ST_CLEAR, ST_IDLE, ST_RMW, ST_DIVC, ST_WAITC, ST_OUT
	} state_t;

	// registers
	logic [12:0] src_width_q, src_height_q, dst_width_q;
	logic [2:0]  channels_q;
	logic        wr_en;
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= bfd_pkg::RST_SRC_WIDTH;
			src_height_q <= bfd_pkg::RST_SRC_HEIGHT;
			dst_width_q  <= bfd_pkg::RST_DST_WIDTH;
			channels_q   <= bfd_pkg::RST_CHANNELS;
		end else if (wr_en) begin
			unique case (bfd_pkg::reg_idx_t'(paddr[3:2]))
				bfd_pkg::REG_SRC_WIDTH:  src_width_q  <= pwdata[12:0];
				bfd_pkg::REG_SRC_HEIGHT: src_height_q <= pwdata[12:0];
				bfd_pkg::REG_DST_WIDTH:  dst_width_q  <= pwdata[12:0];
				bfd_pkg::REG_CHANNELS:   channels_q   <= pwdata[2:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		unique case (bfd_pkg::reg_idx_t'(paddr[3:2]))
			bfd_pkg::REG_SRC_WIDTH:  prdata = {19'd0, src_width_q};
			bfd_pkg::REG_SRC_HEIGHT: prdata = {19'd0, src_height_q};
			bfd_pkg::REG_DST_WIDTH:  prdata = {19'd0, dst_width_q};
			bfd_pkg::REG_CHANNELS:   prdata = {29'd0, channels_q};
			default:                 prdata = '0;
		endcase
	end

	// clamped register values
	logic [XW-1:0]  eff_sw, eff_dw;
	logic [YW-1:0]  eff_sh;
	logic [CHW-1:0] eff_ch;
	always_comb begin
		eff_sw = (src_width_q == 13'd0) ? XW'(1) :
			(32'(src_width_q) > 32'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(src_width_q);
		eff_sh = (src_height_q == 13'd0) ? YW'(1) :
			(32'(src_height_q) > 32'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT) : YW'(src_height_q);
		eff_dw = (dst_width_q == 13'd0) ? XW'(1) :
			(32'(dst_width_q) > 32'(eff_sw)) ? eff_sw : XW'(dst_width_q);
		eff_ch = (channels_q == 3'd0) ? CHW'(1) :
			(32'(channels_q) > 32'(MAX_CHANNELS)) ? CHW'(MAX_CHANNELS) : channels_q;
	end

	// shared divider
	logic          div_start, div_busy;
	logic [NW-1:0] div_num, div_quo;
	logic [31:0]   div_den;
	bfd_div #(.NW(NW), .DW(32)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .busy(div_busy), .quo(div_quo)
	);

	// sum store, one word per column holding all channels
	localparam int MW = SUMW * MAX_CHANNELS;
	logic [MW-1:0] mem [MAX_WIDTH];
	logic          mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [MW-1:0] mem_wd, mem_rd;
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		mem_rd <= mem[mem_ra];
	end

	state_t         state_q;
	logic [YW-1:0]  th_q;
	logic [SW-1:0]  xs_q, ys_q;
	logic [XW-1:0]  src_x_q, out_col_q, xb_start_q, xb_end_q;
	logic [YW-1:0]  src_y_q, out_row_q, yb_start_q, yb_end_q;
	logic [NW-1:0]  xacc_q, yacc_q;
	logic [AW:0]    clr_q;
	logic [7:0]     pix_q [MAX_CHANNELS];
	logic [MW-1:0]  sum_q;
	logic [31:0]    area_q;
	logic [CHW-1:0] ch_q;
	logic [7:0]     res_q [4];
	bfd_pkg::acc_ctl_t ctl_q;
	logic           cfg_dirty_q;

	// box membership of the current pixel
	logic in_box, x_end, y_end, row_done;
	assign in_box   = (out_row_q < th_q) && (out_col_q < eff_dw);
	assign x_end    = (XW'(src_x_q + 1'b1) == xb_end_q);
	assign y_end    = (YW'(src_y_q + 1'b1) == yb_end_q);
	assign row_done = (XW'(src_x_q + 1'b1) >= eff_sw);

	assign pix_stall = (state_q != ST_IDLE) || cfg_dirty_q || wr_en;
	assign mem_ra    = (state_q == ST_IDLE) ? AW'(out_col_q) : AW'(out_col_q);

	logic [NW-1:0] xacc_n, yacc_n;
	assign xacc_n = xacc_q + NW'(xs_q);
	assign yacc_n = yacc_q + NW'(ys_q);

	// read-modify-write sum in rmw stage
	logic [MW-1:0] new_sum;
	always_comb begin
		new_sum = mem_rd;
		for (int c = 0; c < MAX_CHANNELS; c++)
			if (CHW'(c) < eff_ch)
				new_sum[c*SUMW +: SUMW] = mem_rd[c*SUMW +: SUMW] + SUMW'(pix_q[c]);
	end

	// store write port and divider launch
	always_comb begin
		mem_we    = 1'b0;
		mem_wa    = AW'(out_col_q);
		mem_wd    = new_sum;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = 32'd1;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q[AW-1:0];
				mem_wd = '0;
			end
			ST_DIV_H: begin
				div_start = 1'b1;
				div_num   = NW'(32'(eff_sh) * 32'(eff_dw));
				div_den   = 32'(eff_sw);
			end
			ST_DIV_X: begin
				div_start = 1'b1;
				div_num   = NW'(eff_sw) << FRAC_BITS;
				div_den   = 32'(eff_dw);
			end
			ST_DIV_Y: begin
				div_start = 1'b1;
				div_num   = NW'(eff_sh) << FRAC_BITS;
				div_den   = 32'(th_q);
			end
			ST_DIVC: begin
				div_start = 1'b1;
				div_num   = NW'(sum_q[32'(ch_q)*SUMW +: SUMW]);
				div_den   = area_q;
			end
			default: ;
		endcase
		if (state_q == ST_RMW && ctl_q.in_box) mem_we = 1'b1;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_DIV_H;
			avg_valid   <= 1'b0;
			cfg_dirty_q <= 1'b0;
			clr_q       <= '0;
		end else begin
			if (state_q == ST_DIV_H) cfg_dirty_q <= wr_en;
			else if (wr_en) cfg_dirty_q <= 1'b1;
			if (state_q == ST_OUT && !(avg_valid && avg_stall)) avg_valid <= 1'b1;
			else if (avg_valid && !avg_stall) avg_valid <= 1'b0;
			unique case (state_q)
				ST_DIV_H: state_q <= ST_WAIT_H;
				ST_WAIT_H: if (!div_busy) begin
					th_q    <= (div_quo == '0) ? YW'(1) : YW'(div_quo);
					state_q <= ST_DIV_X;
				end
				ST_DIV_X: state_q <= ST_WAIT_X;
				ST_WAIT_X: if (!div_busy) begin
					xs_q    <= SW'(div_quo);
					state_q <= ST_DIV_Y;
				end
				ST_DIV_Y: state_q <= ST_WAIT_Y;
				ST_WAIT_Y: if (!div_busy) begin
					ys_q    <= SW'(div_quo);
					state_q <= ST_BND;
				end
				ST_BND: begin
					src_x_q    <= '0;
					src_y_q    <= '0;
					out_col_q  <= '0;
					out_row_q  <= '0;
					xb_start_q <= '0;
					yb_start_q <= '0;
					xacc_q     <= NW'(xs_q);
					yacc_q     <= NW'(ys_q);
					xb_end_q   <= XW'(NW'(xs_q) >> FRAC_BITS);
					yb_end_q   <= YW'(NW'(ys_q) >> FRAC_BITS);
					clr_q      <= '0;
					state_q    <= ST_CLEAR;
				end
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(MAX_WIDTH - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cfg_dirty_q || wr_en) begin
						state_q <= ST_DIV_H;
					end else if (pix_valid) begin
						pix_q[0] <= pix_ch0;
						if (MAX_CHANNELS > 1) pix_q[1 % MAX_CHANNELS] <= pix_ch1;
						if (MAX_CHANNELS > 2) pix_q[2 % MAX_CHANNELS] <= pix_ch2;
						if (MAX_CHANNELS > 3) pix_q[3 % MAX_CHANNELS] <= pix_ch3;
						ctl_q.in_box <= in_box;
						ctl_q.emit   <= in_box && x_end && y_end;
						ctl_q.last   <= (XW'(out_col_q + 1'b1) == eff_dw) &&
							(YW'(out_row_q + 1'b1) == th_q);
						ctl_q.clear  <= 1'b0;
						area_q <= 32'(XW'(xb_end_q - xb_start_q)) *
							32'(YW'(yb_end_q - yb_start_q));
						state_q <= ST_RMW;
					end
				end
				ST_RMW: begin
					sum_q <= new_sum;
					ch_q  <= '0;
					// advance source position and box bounds
					if (out_col_q < eff_dw && x_end) begin
						out_col_q  <= out_col_q + 1'b1;
						xb_start_q <= xb_end_q;
						xb_end_q   <= XW'(xacc_n >> FRAC_BITS);
						xacc_q     <= xacc_n;
					end
					src_x_q <= src_x_q + 1'b1;
					state_q <= ctl_q.emit ? ST_DIVC : ST_IDLE;
					if (row_done) begin
						src_x_q    <= '0;
						out_col_q  <= '0;
						xb_start_q <= '0;
						xacc_q     <= NW'(xs_q);
						xb_end_q   <= XW'(NW'(xs_q) >> FRAC_BITS);
						src_y_q    <= src_y_q + 1'b1;
						if (out_row_q < th_q && y_end) begin
							out_row_q  <= out_row_q + 1'b1;
							yb_start_q <= yb_end_q;
							yb_end_q   <= YW'(yacc_n >> FRAC_BITS);
							yacc_q     <= yacc_n;
							clr_q      <= '0;
							if (!ctl_q.emit) state_q <= ST_CLEAR;
							ctl_q.clear <= 1'b1;
						end
						if (YW'(src_y_q + 1'b1) >= eff_sh) begin
							state_q <= ctl_q.emit ? ST_DIVC : ST_BND;
							ctl_q.clear <= 1'b1;
						end
					end
				end
				ST_DIVC: state_q <= ST_WAITC;
				ST_WAITC: if (!div_busy) begin
					res_q[ch_q[1:0]] <= div_quo[7:0];
					ch_q <= ch_q + 1'b1;
					state_q <= (CHW'(ch_q + 1'b1) >= eff_ch) ? ST_OUT : ST_DIVC;
				end
				// wait here while an earlier result is still held
				ST_OUT: if (!(avg_valid && avg_stall)) begin
					avg_ch0    <= res_q[0];
					avg_ch1    <= (eff_ch > CHW'(1)) ? res_q[1] : 8'd0;
					avg_ch2    <= (eff_ch > CHW'(2)) ? res_q[2] : 8'd0;
					avg_ch3    <= (eff_ch > CHW'(3)) ? res_q[3] : 8'd0;
					frame_last <= ctl_q.last;
					if (ctl_q.clear) begin
						clr_q   <= '0;
						state_q <= (src_y_q >= eff_sh) ? ST_BND : ST_CLEAR;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	// a stalled result word stays put
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(avg_valid && avg_stall) |=> (avg_valid && $stable(avg_ch0) &&
		$stable(avg_ch1) && $stable(avg_ch2) && $stable(avg_ch3) &&
		$stable(frame_last))) else $error("stalled result changed");
	// pixels are only taken in the idle state
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && !pix_stall) |=> (state_q == ST_RMW || state_q == ST_DIV_H))
		else $error("pixel taken outside idle");
	// divider never restarted while busy
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy) else $error("divider restarted");
`endif
endmodule
`default_nettype wire
